FILE: sv/gsac_pkg.sv
package gsac_pkg;

   // divider operand widths
   localparam int NUM_W = 50;
   localparam int DEN_W = 19;
   localparam int SN_W  = NUM_W + 1;

   // register indexes on the csr port
   localparam logic [2:0] CSR_ARMED     = 3'd0;
   localparam logic [2:0] CSR_ALT_TGT   = 3'd1;
   localparam logic [2:0] CSR_PITCH_TGT = 3'd2;
   localparam logic [2:0] CSR_HDG_TGT   = 3'd3;
   localparam logic [2:0] CSR_HDG_GIVEN = 3'd4;
   localparam logic [2:0] CSR_THR_TRIM  = 3'd5;

   // vertical mode codes
   localparam logic [1:0] MODE_LEVEL   = 2'd0;
   localparam logic [1:0] MODE_CLIMB   = 2'd1;
   localparam logic [1:0] MODE_DESCEND = 2'd2;

   localparam logic [15:0]        DT_DEFAULT  = 16'd1311;
   localparam logic [15:0]        DT_MAX      = 16'd32768;
   localparam logic signed [15:0] HALF_TURN   = 16'sd11520;
   localparam logic signed [15:0] FULL_TURN   = 16'sd23040;
   localparam int                 THR_FULL    = 4096;
   localparam logic signed [23:0] ALT_I_LIM   = 24'sd6710886;
   localparam logic signed [23:0] PITCH_I_LIM = 24'sd2621440;
   localparam logic [11:0]        CMD_LIM     = 12'd1920;
   localparam logic signed [15:0] G_KP_ALT    = 16'sd9830;
   localparam logic signed [15:0] G_KI_ALT    = 16'sd1966;
   localparam logic signed [15:0] G_KD_ALT    = 16'sd6554;
   localparam logic signed [15:0] G_KI_PITCH  = 16'sd19661;
   localparam logic signed [15:0] G_KD_PITCH  = 16'sd26214;
   localparam logic signed [17:0] G_KP_YAW    = 18'sd78643;
   localparam logic signed [15:0] V_ENTER     = 16'sd77;
   localparam logic signed [15:0] V_LEAVE     = 16'sd25;

   localparam int BASE_PITCH [0:4] = '{1434, 2662, 4096, 5939, 7578};
   localparam int BASE_YAW   [0:4] = '{1229, 2253, 4096, 5734, 6963};

   typedef enum logic [1:0] {DIV_PD, DIV_YD, DIV_EL, DIV_RU} div_sel_type;

   typedef struct packed {
      logic        load;
      logic        prep;
      logic        mul1;
      logic        integ;
      logic        mul2;
      logic        thr;
      logic        sch1;
      logic        sch2;
      logic        sch3;
      logic        div_start;
      logic        div_take;
      div_sel_type div_sel;
      logic        sum;
      logic        fin;
   } gsac_cmd_type;

   typedef struct packed {
      logic active;
      logic div_done;
      logic out_free;
   } gsac_status_type;

   // effectiveness curve over throttle, evaluated at elaboration for the nodes
   function automatic int base_curve(input bit yaw, input int thr);
      int seg;
      int lo;
      int hi;
      int t;
      seg = thr >>> 10;
      if (seg >= 4) begin
         return yaw ? BASE_YAW[4] : BASE_PITCH[4];
      end
      lo = yaw ? BASE_YAW[seg] : BASE_PITCH[seg];
      hi = yaw ? BASE_YAW[seg + 1] : BASE_PITCH[seg + 1];
      t  = (hi - lo) * (thr & 1023) + 512;
      return lo + (t >>> 10);
   endfunction

endpackage

FILE: sv/gsac_if.sv
interface gsac_req_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] pitch_angle;
   logic [14:0]        heading_angle;
   logic signed [15:0] altitude;
   logic signed [15:0] vertical_speed;
   logic [15:0]        step_time;
   logic               sample_valid;

   modport source (output valid, pitch_angle, heading_angle, altitude, vertical_speed,
                   step_time, sample_valid, input ready);
   modport sink (input valid, pitch_angle, heading_angle, altitude, vertical_speed,
                 step_time, sample_valid, output ready);
endinterface

interface gsac_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [11:0] elevator;
   logic signed [11:0] rudder;
   logic [12:0]        throttle;
   logic signed [14:0] pitch_target_echo;
   logic [1:0]         climb_state;
   logic               armed_flag;

   modport source (output valid, elevator, rudder, throttle, pitch_target_echo,
                   climb_state, armed_flag, input ready);
   modport sink (input valid, elevator, rudder, throttle, pitch_target_echo,
                 climb_state, armed_flag, output ready);
endinterface

FILE: sv/gsac_div.sv
module gsac_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gsac_pkg::NUM_W-1:0]    dividend,
   input  logic [gsac_pkg::DEN_W-1:0]    divisor,
   output logic                          done,
   output logic [gsac_pkg::NUM_W-1:0]    quotient
);
   import gsac_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial_in;
   logic             fit_in;

   assign trial_in = {rem_ff, quo_ff[NUM_W-1]};
   assign fit_in   = trial_in >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // one quotient bit per cycle, restoring
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fit_in};
         rem_ff <= fit_in ? DEN_W'(trial_in - {1'b0, den_ff}) : trial_in[DEN_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/gsac_ctrl.sv
module gsac_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output gsac_pkg::gsac_cmd_type    cmd,
   input  gsac_pkg::gsac_status_type status
);
   import gsac_pkg::*;

   typedef enum logic [18:0] {
      S_IDLE   = 19'b0000000000000000001,
      S_PREP   = 19'b0000000000000000010,
      S_MUL1   = 19'b0000000000000000100,
      S_INTEG  = 19'b0000000000000001000,
      S_MUL2   = 19'b0000000000000010000,
      S_THR    = 19'b0000000000000100000,
      S_SCH1   = 19'b0000000000001000000,
      S_SCH2   = 19'b0000000000010000000,
      S_SCH3   = 19'b0000000000100000000,
      S_DPD_GO = 19'b0000000001000000000,
      S_DPD_WT = 19'b0000000010000000000,
      S_DYD_GO = 19'b0000000100000000000,
      S_DYD_WT = 19'b0000001000000000000,
      S_SUM    = 19'b0000010000000000000,
      S_DEL_GO = 19'b0000100000000000000,
      S_DEL_WT = 19'b0001000000000000000,
      S_DRU_GO = 19'b0010000000000000000,
      S_DRU_WT = 19'b0100000000000000000,
      S_FIN    = 19'b1000000000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.active ? S_MUL1 : S_FIN;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_INTEG;
         end
         S_INTEG: begin
            cmd.integ = 1'b1;
            state_in  = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_THR;
         end
         S_THR: begin
            cmd.thr  = 1'b1;
            state_in = S_SCH1;
         end
         S_SCH1: begin
            cmd.sch1 = 1'b1;
            state_in = S_SCH2;
         end
         S_SCH2: begin
            cmd.sch2 = 1'b1;
            state_in = S_SCH3;
         end
         S_SCH3: begin
            cmd.sch3 = 1'b1;
            state_in = S_DPD_GO;
         end
         S_DPD_GO: begin
            cmd.div_sel   = DIV_PD;
            cmd.div_start = 1'b1;
            state_in      = S_DPD_WT;
         end
         S_DPD_WT: begin
            cmd.div_sel = DIV_PD;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_DYD_GO;
            end
         end
         S_DYD_GO: begin
            cmd.div_sel   = DIV_YD;
            cmd.div_start = 1'b1;
            state_in      = S_DYD_WT;
         end
         S_DYD_WT: begin
            cmd.div_sel = DIV_YD;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_DEL_GO;
         end
         S_DEL_GO: begin
            cmd.div_sel   = DIV_EL;
            cmd.div_start = 1'b1;
            state_in      = S_DEL_WT;
         end
         S_DEL_WT: begin
            cmd.div_sel = DIV_EL;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_DRU_GO;
            end
         end
         S_DRU_GO: begin
            cmd.div_sel   = DIV_RU;
            cmd.div_start = 1'b1;
            state_in      = S_DRU_WT;
         end
         S_DRU_WT: begin
            cmd.div_sel = DIV_RU;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_FIN;
            end
         end
         S_FIN: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

FILE: sv/gsac_dp.sv
module gsac_dp #(
   parameter int BREAKPOINTS = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gsac_pkg::gsac_cmd_type     cmd,
   output gsac_pkg::gsac_status_type  status,
   input  logic signed [14:0]         req_pitch_angle,
   input  logic [14:0]                req_heading_angle,
   input  logic signed [15:0]         req_altitude,
   input  logic signed [15:0]         req_vertical_speed,
   input  logic [15:0]                req_step_time,
   input  logic                       req_sample_valid,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [11:0]         rsp_elevator,
   output logic signed [11:0]         rsp_rudder,
   output logic [12:0]                rsp_throttle,
   output logic signed [14:0]         rsp_pitch_target_echo,
   output logic [1:0]                 rsp_climb_state,
   output logic                       rsp_armed_flag,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_index,
   input  logic [15:0]                csr_wdata
);
   import gsac_pkg::*;

   localparam int SEG_W  = $clog2(BREAKPOINTS);
   localparam int POS_W  = 13 + SEG_W;
   localparam int SEGF_W = POS_W - 12;

   function automatic logic signed [14:0] wrap_angle(input logic signed [15:0] a);
      logic signed [15:0] r;
      r = a;
      if (a > HALF_TURN) begin
         r = a - FULL_TURN;
      end else if (a < -HALF_TURN) begin
         r = a + FULL_TURN;
      end
      return r[14:0];
   endfunction

   // schedule nodes
   logic [12:0] node_p [BREAKPOINTS];
   logic [12:0] node_y [BREAKPOINTS];
   for (genvar j = 0; j < BREAKPOINTS; j++) begin : g_node
      localparam int NODE_THR = (j * THR_FULL + (BREAKPOINTS - 1) / 2) / (BREAKPOINTS - 1);
      assign node_p[j] = 13'(base_curve(1'b0, NODE_THR));
      assign node_y[j] = 13'(base_curve(1'b1, NODE_THR));
   end

   // configuration
   logic               armed_ff;
   logic signed [15:0] alt_tgt_ff;
   logic signed [14:0] ptgt_ff;
   logic [14:0]        htgt_ff;
   logic               hgiven_ff;
   logic [12:0]        trim_ff;

   // persistent state
   logic signed [23:0] ai_ff;
   logic signed [23:0] pi_ff;
   logic signed [14:0] prev_pitch_ff;
   logic [14:0]        prev_hdg_ff;
   logic               primed_ff;
   logic [1:0]         mode_ff;
   logic [14:0]        capt_ff;
   logic               hcap_ff;

   // sample
   logic signed [14:0] pitch_ff;
   logic [14:0]        heading_ff;
   logic signed [15:0] alt_ff;
   logic signed [15:0] vel_ff;
   logic [15:0]        dt_ff;
   logic               active_ff;

   // working registers
   logic signed [16:0] d_ff;
   logic signed [15:0] ep_ff;
   logic signed [15:0] dp_ff;
   logic signed [14:0] ey_ff;
   logic signed [14:0] dh_ff;
   logic signed [33:0] m_ai_ff;
   logic signed [32:0] m_pi_ff;
   logic signed [31:0] m_ap_ff;
   logic signed [30:0] m_vel_ff;
   logic signed [32:0] m_yaw_ff;
   logic signed [31:0] m_pd_ff;
   logic signed [35:0] t_ai_ff;
   logic signed [39:0] t_pi_ff;
   logic [12:0]        thr_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [12:0]        v0_p_ff;
   logic [12:0]        v0_y_ff;
   logic signed [25:0] prod_p_ff;
   logic signed [25:0] prod_y_ff;
   logic [12:0]        kp_p_ff;
   logic [12:0]        kp_y_ff;
   logic signed [SN_W-1:0] qpd_ff;
   logic signed [SN_W-1:0] qyd_ff;
   logic signed [SN_W-1:0] sum_p_ff;
   logic signed [SN_W-1:0] sum_y_ff;
   logic signed [11:0] elev_ff;
   logic signed [11:0] rud_ff;

   // result register
   logic               rsp_valid_ff;
   logic signed [11:0] rsp_elev_ff;
   logic signed [11:0] rsp_rud_ff;
   logic [12:0]        rsp_thr_ff;
   logic signed [14:0] rsp_echo_ff;
   logic [1:0]         rsp_mode_ff;
   logic               rsp_armed_ff;

   // next values
   logic [15:0]        dt_in;
   logic [14:0]        href_in;
   logic signed [23:0] ai_in;
   logic signed [23:0] pi_in;
   logic [12:0]        thr_in;
   logic [12:0]        v0_p_in;
   logic [12:0]        v0_y_in;
   logic signed [25:0] prod_p_in;
   logic signed [25:0] prod_y_in;
   logic [12:0]        kp_p_in;
   logic [12:0]        kp_y_in;
   logic [1:0]         mode_in;
   logic [NUM_W-1:0]   div_num_in;
   logic [DEN_W-1:0]   div_den_in;
   logic               div_neg_in;
   logic signed [SN_W-1:0] div_q_in;
   logic [11:0]        cmd_mag_in;
   logic signed [11:0] cmd_in;
   logic signed [SN_W-1:0] sum_p_in;
   logic signed [SN_W-1:0] sum_y_in;

   logic               div_done;
   logic [NUM_W-1:0]   div_quo;

   always_comb begin
      dt_in = req_step_time;
      if (req_step_time == 16'd0 || req_step_time > DT_MAX) begin
         dt_in = DT_DEFAULT;
      end
      href_in = hgiven_ff ? htgt_ff : (hcap_ff ? capt_ff : heading_ff);
   end

   // integrator updates
   always_comb begin
      logic signed [34:0] ai_sum;
      logic signed [33:0] pi_rnd;
      logic signed [34:0] pi_sum;
      ai_sum = 35'(ai_ff) + 35'(m_ai_ff);
      pi_rnd = (34'(m_pi_ff) + 34'sd8) >>> 4;
      pi_sum = 35'(pi_ff) + 35'(pi_rnd);
      if (ai_sum > 35'(ALT_I_LIM)) begin
         ai_in = ALT_I_LIM;
      end else if (ai_sum < -35'(ALT_I_LIM)) begin
         ai_in = -ALT_I_LIM;
      end else begin
         ai_in = ai_sum[23:0];
      end
      if (pi_sum > 35'(PITCH_I_LIM)) begin
         pi_in = PITCH_I_LIM;
      end else if (pi_sum < -35'(PITCH_I_LIM)) begin
         pi_in = -PITCH_I_LIM;
      end else begin
         pi_in = pi_sum[23:0];
      end
   end

   // altitude loop sum to throttle
   always_comb begin
      logic signed [35:0] s_ai;
      logic signed [34:0] sum_t;
      logic signed [34:0] sh;
      s_ai  = (t_ai_ff + 36'sd32768) >>> 16;
      sum_t = 35'($signed({1'b0, trim_ff, 12'b0})) + 35'(m_ap_ff) + 35'(s_ai)
            - 35'(m_vel_ff);
      sh    = (sum_t + 35'sd2048) >>> 12;
      if (sh < 35'sd0) begin
         thr_in = 13'd0;
      end else if (sh > 35'(THR_FULL)) begin
         thr_in = 13'(THR_FULL);
      end else begin
         thr_in = sh[12:0];
      end
   end

   // schedule interpolation
   always_comb begin
      logic [SEGF_W-1:0]  seg;
      logic               sat;
      logic [SEG_W-1:0]   idx;
      logic [SEG_W-1:0]   idx1;
      logic [11:0]        frac;
      logic signed [13:0] dif_p;
      logic signed [13:0] dif_y;
      logic signed [26:0] rp;
      logic signed [26:0] ry;
      seg   = pos_ff[POS_W-1:12];
      sat   = seg >= SEGF_W'(BREAKPOINTS - 1);
      idx   = sat ? SEG_W'(BREAKPOINTS - 2) : seg[SEG_W-1:0];
      idx1  = idx + 1'b1;
      frac  = pos_ff[11:0];
      v0_p_in = sat ? node_p[BREAKPOINTS-1] : node_p[idx];
      v0_y_in = sat ? node_y[BREAKPOINTS-1] : node_y[idx];
      dif_p = $signed({1'b0, node_p[idx1]}) - $signed({1'b0, v0_p_in});
      dif_y = $signed({1'b0, node_y[idx1]}) - $signed({1'b0, v0_y_in});
      prod_p_in = sat ? 26'sd0 : 26'(dif_p) * 26'($signed({1'b0, frac}));
      prod_y_in = sat ? 26'sd0 : 26'(dif_y) * 26'($signed({1'b0, frac}));
      rp = (27'(prod_p_ff) + 27'sd2048) >>> 12;
      ry = (27'(prod_y_ff) + 27'sd2048) >>> 12;
      kp_p_in = 13'($signed({1'b0, v0_p_ff}) + 14'(rp));
      kp_y_in = 13'($signed({1'b0, v0_y_ff}) + 14'(ry));
   end

   // divider operands and result
   always_comb begin
      logic signed [SN_W-1:0] sn;
      logic [SN_W-1:0]        mag;
      sn         = SN_W'(m_pd_ff) <<< 18;
      div_den_in = DEN_W'(dt_ff);
      unique case (cmd.div_sel)
         DIV_PD: begin
            sn         = SN_W'(m_pd_ff) <<< 18;
            div_den_in = DEN_W'(dt_ff);
         end
         DIV_YD: begin
            sn         = SN_W'(dh_ff) <<< 32;
            div_den_in = DEN_W'(dt_ff);
         end
         DIV_EL: begin
            sn         = sum_p_ff;
            div_den_in = {kp_p_ff, 6'b0};
         end
         DIV_RU: begin
            sn         = sum_y_ff;
            div_den_in = {kp_y_ff, 6'b0};
         end
         default: begin
            sn         = sum_p_ff;
            div_den_in = {kp_p_ff, 6'b0};
         end
      endcase
      div_neg_in = sn[SN_W-1];
      mag        = div_neg_in ? -sn : sn;
      div_num_in = NUM_W'(mag + SN_W'(div_den_in >> 1));
      div_q_in   = div_neg_in ? -SN_W'({1'b0, div_quo}) : SN_W'({1'b0, div_quo});
      cmd_mag_in = (div_quo > NUM_W'(CMD_LIM)) ? CMD_LIM : div_quo[11:0];
      cmd_in     = div_neg_in ? -$signed(cmd_mag_in) : $signed(cmd_mag_in);
   end

   always_comb begin
      logic signed [40:0] tpi;
      tpi      = (41'(t_pi_ff) + 41'sd512) >>> 10;
      sum_p_in = (SN_W'(ep_ff) <<< 19) + SN_W'(tpi) - (primed_ff ? qpd_ff : SN_W'(0));
      sum_y_in = (SN_W'(m_yaw_ff) <<< 2) - (primed_ff ? qyd_ff : SN_W'(0));
   end

   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_LEVEL: begin
            if (vel_ff >= V_ENTER) begin
               mode_in = MODE_CLIMB;
            end else if (vel_ff <= -V_ENTER) begin
               mode_in = MODE_DESCEND;
            end
         end
         MODE_CLIMB:   mode_in = (vel_ff <= V_LEAVE) ? MODE_LEVEL : MODE_CLIMB;
         MODE_DESCEND: mode_in = (vel_ff >= -V_LEAVE) ? MODE_LEVEL : MODE_DESCEND;
         default:      mode_in = MODE_LEVEL;
      endcase
   end

   gsac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num_in),
      .divisor  (div_den_in),
      .done     (div_done),
      .quotient (div_quo)
   );

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= 1'b0;
         alt_tgt_ff    <= 16'sd256;
         ptgt_ff       <= '0;
         htgt_ff       <= '0;
         hgiven_ff     <= 1'b0;
         trim_ff       <= 13'd1638;
         ai_ff         <= '0;
         pi_ff         <= '0;
         prev_pitch_ff <= '0;
         prev_hdg_ff   <= '0;
         primed_ff     <= 1'b0;
         mode_ff       <= MODE_LEVEL;
         capt_ff       <= '0;
         hcap_ff       <= 1'b0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            active_ff <= armed_ff & req_sample_valid;
         end
         if (cmd.prep && active_ff && !hcap_ff) begin
            capt_ff <= heading_ff;
            hcap_ff <= 1'b1;
         end
         if (cmd.integ) begin
            ai_ff <= ai_in;
            pi_ff <= pi_in;
         end
         if (cmd.fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.fin) begin
            prev_pitch_ff <= pitch_ff;
            prev_hdg_ff   <= heading_ff;
            primed_ff     <= 1'b1;
            if (active_ff) begin
               mode_ff <= mode_in;
            end else begin
               ai_ff <= '0;
               pi_ff <= '0;
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_ARMED: begin
                  armed_ff <= csr_wdata[0];
                  if (csr_wdata[0]) begin
                     ai_ff   <= '0;
                     pi_ff   <= '0;
                     hcap_ff <= 1'b0;
                  end
               end
               CSR_ALT_TGT:   alt_tgt_ff <= $signed(csr_wdata);
               CSR_PITCH_TGT: ptgt_ff    <= $signed(csr_wdata[14:0]);
               CSR_HDG_TGT:   htgt_ff    <= csr_wdata[14:0];
               CSR_HDG_GIVEN: hgiven_ff  <= csr_wdata[0];
               CSR_THR_TRIM: begin
                  trim_ff <= (csr_wdata[12:0] > 13'(THR_FULL)) ? 13'(THR_FULL)
                                                               : csr_wdata[12:0];
               end
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pitch_ff   <= req_pitch_angle;
         heading_ff <= req_heading_angle;
         alt_ff     <= req_altitude;
         vel_ff     <= req_vertical_speed;
         dt_ff      <= dt_in;
      end
      if (cmd.prep) begin
         d_ff  <= 17'(alt_tgt_ff) - 17'(alt_ff);
         ep_ff <= 16'(ptgt_ff) - 16'(pitch_ff);
         dp_ff <= 16'(pitch_ff) - 16'(prev_pitch_ff);
         ey_ff <= wrap_angle($signed({1'b0, href_in}) - $signed({1'b0, heading_ff}));
         dh_ff <= wrap_angle($signed({1'b0, heading_ff}) - $signed({1'b0, prev_hdg_ff}));
      end
      if (cmd.mul1) begin
         m_ai_ff  <= 34'(d_ff) * 34'($signed({1'b0, dt_ff}));
         m_pi_ff  <= 33'(ep_ff) * 33'($signed({1'b0, dt_ff}));
         m_ap_ff  <= 32'(d_ff) * 32'(G_KP_ALT);
         m_vel_ff <= 31'(vel_ff) * 31'(G_KD_ALT);
         m_yaw_ff <= 33'(ey_ff) * 33'(G_KP_YAW);
         m_pd_ff  <= 32'(dp_ff) * 32'(G_KD_PITCH);
      end
      if (cmd.mul2) begin
         t_ai_ff <= 36'(ai_ff) * 36'(G_KI_ALT);
         t_pi_ff <= 40'(pi_ff) * 40'(G_KI_PITCH);
      end
      if (cmd.thr) begin
         thr_ff <= thr_in;
      end
      if (cmd.sch1) begin
         pos_ff <= POS_W'(thr_ff) * POS_W'(BREAKPOINTS - 1);
      end
      if (cmd.sch2) begin
         v0_p_ff   <= v0_p_in;
         v0_y_ff   <= v0_y_in;
         prod_p_ff <= prod_p_in;
         prod_y_ff <= prod_y_in;
      end
      if (cmd.sch3) begin
         kp_p_ff <= kp_p_in;
         kp_y_ff <= kp_y_in;
      end
      if (cmd.div_take) begin
         unique case (cmd.div_sel)
            DIV_PD:  qpd_ff  <= div_q_in;
            DIV_YD:  qyd_ff  <= div_q_in;
            DIV_EL:  elev_ff <= cmd_in;
            DIV_RU:  rud_ff  <= cmd_in;
            default: ;
         endcase
      end
      if (cmd.sum) begin
         sum_p_ff <= sum_p_in;
         sum_y_ff <= sum_y_in;
      end
      if (cmd.fin) begin
         rsp_echo_ff  <= ptgt_ff;
         rsp_armed_ff <= armed_ff;
         if (active_ff) begin
            rsp_elev_ff <= elev_ff;
            rsp_rud_ff  <= rud_ff;
            rsp_thr_ff  <= thr_ff;
            rsp_mode_ff <= mode_in;
         end else begin
            rsp_elev_ff <= '0;
            rsp_rud_ff  <= '0;
            rsp_thr_ff  <= armed_ff ? trim_ff : 13'd0;
            rsp_mode_ff <= mode_ff;
         end
      end
   end

   assign status.active   = active_ff;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_elevator          = rsp_elev_ff;
   assign rsp_rudder            = rsp_rud_ff;
   assign rsp_throttle          = rsp_thr_ff;
   assign rsp_pitch_target_echo = rsp_echo_ff;
   assign rsp_climb_state       = rsp_mode_ff;
   assign rsp_armed_flag        = rsp_armed_ff;

endmodule

FILE: sv/gain_scheduled_attitude_altitude_ctrl.sv
// Gain-scheduled altitude / pitch / heading controller.
// req_if carries one fused sample per transfer (valid/ready). rsp_if returns
// exactly one command set per sample: elevator, rudder, throttle, the pitch
// setpoint in use, climb state and the armed flag.
// csr_we/csr_index/csr_wdata write the setpoint and arming registers; write
// them only while no sample is in flight.
// An armed, valid sample runs 10 steps plus four 50-step divisions, one after
// another on the shared radix-2 divider, each with its own start and hand-off.
// A disarmed or invalid sample goes from the prep step straight to the result.
// One sample is worked on at a time; the next is taken the cycle after the
// previous result is registered, also while that result still waits.
// Reset clears the integrators, the rate history and heading capture, puts
// the climb state to level and loads the register defaults (disarmed,
// altitude target 1 m, throttle trim 1638).
// A stalled result is held in the output register; a second finished result
// waits inside the block until the first is taken.
module gain_scheduled_attitude_altitude_ctrl #(
   parameter int BREAKPOINTS = 5
) (
   input  logic        clock,
   input  logic        reset,
   gsac_req_if.sink    req_if,
   gsac_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import gsac_pkg::*;

   gsac_cmd_type    cmd;
   gsac_status_type status;

   gsac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   gsac_dp #(
      .BREAKPOINTS (BREAKPOINTS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_pitch_angle       (req_if.pitch_angle),
      .req_heading_angle     (req_if.heading_angle),
      .req_altitude          (req_if.altitude),
      .req_vertical_speed    (req_if.vertical_speed),
      .req_step_time         (req_if.step_time),
      .req_sample_valid      (req_if.sample_valid),
      .rsp_valid             (rsp_if.valid),
      .rsp_ready             (rsp_if.ready),
      .rsp_elevator          (rsp_if.elevator),
      .rsp_rudder            (rsp_if.rudder),
      .rsp_throttle          (rsp_if.throttle),
      .rsp_pitch_target_echo (rsp_if.pitch_target_echo),
      .rsp_climb_state       (rsp_if.climb_state),
      .rsp_armed_flag        (rsp_if.armed_flag),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

endmodule

FILE: test/tb_gain_scheduled_attitude_altitude_ctrl.sv
module tb_gain_scheduled_attitude_altitude_ctrl;
   import gsac_pkg::*;

   typedef struct {
      logic signed [14:0] pitch;
      logic [14:0]        heading;
      logic signed [15:0] alt;
      logic signed [15:0] vspeed;
      logic [15:0]        dt;
      logic               sample_ok;
   } sample_type;

   typedef struct {
      logic signed [11:0] elevator;
      logic signed [11:0] rudder;
      logic [12:0]        throttle;
      logic signed [14:0] pitch_echo;
      logic [1:0]         climb;
      logic               armed;
   } command_type;

   typedef struct {
      sample_type  s;
      bit          typed;
      command_type c;
   } stim_row_type;

   localparam longint PITCH_CURVE [0:4] = '{1434, 2662, 4096, 5939, 7578};
   localparam longint YAW_CURVE   [0:4] = '{1229, 2253, 4096, 5734, 6963};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_ARMED;
   logic [15:0] csr_wdata = '0;

   gsac_req_if req_bus ();
   gsac_rsp_if rsp_bus ();

   gain_scheduled_attitude_altitude_ctrl i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // controller mirror: registers and state
   bit               m_armed;
   logic signed [15:0] m_alt_tgt;
   logic signed [14:0] m_pitch_tgt;
   logic [14:0]      m_hdg_tgt;
   bit               m_hdg_given;
   longint           m_trim;
   longint           m_pitch_int, m_alt_int, m_prev_pitch, m_prev_hdg, m_capt_hdg;
   bit               m_primed, m_captured;
   logic [1:0]       m_mode;

   command_type pending_cmds [$];
   int  error_count = 0;
   int  max_gap = 6;
   int  max_stall = 6;
   bit  hold_rsp = 1'b0;

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint round_div(longint num, longint den);
      if (num >= 0) begin
         return (num + den / 2) / den;
      end
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint clamp(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic longint wrap_deg(longint d);
      while (d > 11520) d -= 23040;
      while (d < -11520) d += 23040;
      return d;
   endfunction

   function automatic longint curve_at(bit yaw, longint thr);
      longint seg;
      longint lo;
      longint hi;
      seg = thr >>> 10;
      if (seg >= 4) begin
         return yaw ? YAW_CURVE[4] : PITCH_CURVE[4];
      end
      lo = yaw ? YAW_CURVE[seg] : PITCH_CURVE[seg];
      hi = yaw ? YAW_CURVE[seg + 1] : PITCH_CURVE[seg + 1];
      return lo + round_shift((hi - lo) * (thr & 1023), 10);
   endfunction

   function automatic longint effectiveness(bit yaw, longint thr);
      longint pos;
      longint seg;
      longint v0;
      longint v1;
      pos = thr * 4;
      seg = pos >>> 12;
      if (seg >= 4) begin
         return curve_at(yaw, 4096);
      end
      v0 = curve_at(yaw, (seg * 4096 + 2) / 4);
      v1 = curve_at(yaw, ((seg + 1) * 4096 + 2) / 4);
      return v0 + round_shift((v1 - v0) * (pos & 4095), 12);
   endfunction

   function automatic command_type control_step(sample_type s);
      command_type c;
      longint dt, pitch, hdg, alt, vel, d, sum, thr, kp, ky, ep, ey, href, elev, rud;
      pitch = s.pitch;
      hdg = s.heading;
      alt = s.alt;
      vel = s.vspeed;
      dt = s.dt;
      elev = 0;
      rud = 0;
      if (dt == 0 || dt > 32768) dt = 1311;
      if (!m_armed || !s.sample_ok) begin
         m_pitch_int = 0;
         m_alt_int = 0;
         m_prev_pitch = pitch;
         m_prev_hdg = hdg;
         m_primed = 1'b1;
         thr = m_armed ? m_trim : 0;
      end else begin
         if (!m_captured) begin
            m_capt_hdg = hdg;
            m_captured = 1'b1;
         end
         href = m_hdg_given ? longint'(m_hdg_tgt) : m_capt_hdg;
         d = longint'(m_alt_tgt) - alt;
         m_alt_int = clamp(m_alt_int + d * dt, -6710886, 6710886);
         sum = (m_trim << 12) + d * 9830 + round_shift(m_alt_int * 1966, 16) - vel * 6554;
         thr = clamp(round_shift(sum, 12), 0, 4096);
         kp = effectiveness(1'b0, thr);
         ky = effectiveness(1'b1, thr);
         ep = longint'(m_pitch_tgt) - pitch;
         m_pitch_int = clamp(m_pitch_int + round_shift(ep * dt, 4), -2621440, 2621440);
         sum = ep * 131072 * 4 + round_shift(m_pitch_int * 19661, 10);
         if (m_primed) sum -= round_div((pitch - m_prev_pitch) * 26214 * 262144, dt);
         m_prev_pitch = pitch;
         elev = clamp(round_div(sum, kp * 64), -1920, 1920);
         ey = wrap_deg(href - hdg);
         sum = ey * 78643 * 4;
         if (m_primed) sum -= round_div(wrap_deg(hdg - m_prev_hdg) * 16384 * 262144, dt);
         m_prev_hdg = hdg;
         rud = clamp(round_div(sum, ky * 64), -1920, 1920);
         m_primed = 1'b1;
         case (m_mode)
            MODE_LEVEL: begin
               m_mode = vel >= 77 ? MODE_CLIMB : (vel <= -77 ? MODE_DESCEND : MODE_LEVEL);
            end
            MODE_CLIMB: m_mode = vel <= 25 ? MODE_LEVEL : MODE_CLIMB;
            MODE_DESCEND: m_mode = vel >= -25 ? MODE_LEVEL : MODE_DESCEND;
            default: m_mode = MODE_LEVEL;
         endcase
      end
      c.elevator = elev[11:0];
      c.rudder = rud[11:0];
      c.throttle = thr[12:0];
      c.pitch_echo = m_pitch_tgt;
      c.climb = m_mode;
      c.armed = m_armed;
      return c;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ARMED: begin
            m_armed = val[0];
            if (val[0]) begin
               m_captured = 1'b0;
               m_pitch_int = 0;
               m_alt_int = 0;
            end
         end
         CSR_ALT_TGT: m_alt_tgt = val;
         CSR_PITCH_TGT: m_pitch_tgt = val[14:0];
         CSR_HDG_TGT: m_hdg_tgt = val[14:0];
         CSR_HDG_GIVEN: m_hdg_given = val[0];
         CSR_THR_TRIM: m_trim = val[12:0] > 4096 ? 4096 : val[12:0];
         default: ;
      endcase
   endtask

   // drop valid so the last sample is not taken again, then let results drain
   task automatic drain;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // hold valid across back-to-back transfers; predict on acceptance
   task automatic send_sample(sample_type s, bit typed, command_type want);
      command_type c;
      int gap;
      gap = $urandom_range(0, max_gap);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pitch_angle <= s.pitch;
      req_bus.heading_angle <= s.heading;
      req_bus.altitude <= s.alt;
      req_bus.vertical_speed <= s.vspeed;
      req_bus.step_time <= s.dt;
      req_bus.sample_valid <= s.sample_ok;
      do @(posedge clock); while (!req_bus.ready);
      c = control_step(s);
      pending_cmds.push_back(typed ? want : c);
   endtask

   function automatic sample_type random_sample();
      sample_type s;
      s.pitch = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 1600)) - 15'sd800;
      s.heading = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23040));
      s.alt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(m_alt_tgt + $urandom_range(0, 1024) - 512);
      s.vspeed = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300)) - 16'sd150;
      case ($urandom_range(0, 9))
         0: s.dt = 16'($urandom);
         1: s.dt = '0;
         2: s.dt = 16'($urandom_range(32767, 32769));
         default: s.dt = 16'($urandom_range(1000, 1600));
      endcase
      s.sample_ok = $urandom_range(0, 9) != 0;
      return s;
   endfunction

   always @(posedge clock) begin
      command_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_cmds.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            w = pending_cmds.pop_front();
            if (rsp_bus.elevator !== w.elevator) report_mismatch("elevator", rsp_bus.elevator, w.elevator);
            if (rsp_bus.rudder !== w.rudder) report_mismatch("rudder", rsp_bus.rudder, w.rudder);
            if (rsp_bus.throttle !== w.throttle) report_mismatch("throttle", rsp_bus.throttle, w.throttle);
            if (rsp_bus.pitch_target_echo !== w.pitch_echo) begin
               report_mismatch("pitch_target_echo", rsp_bus.pitch_target_echo, w.pitch_echo);
            end
            if (rsp_bus.climb_state !== w.climb) report_mismatch("climb_state", rsp_bus.climb_state, w.climb);
            if (rsp_bus.armed_flag !== w.armed) report_mismatch("armed_flag", rsp_bus.armed_flag, w.armed);
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      int held;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, max_stall);
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            held = 0;
            while (held < 3000) begin
               @(negedge clock);
               held++;
            end
            hold_rsp = 1'b0;
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   initial begin
      #40_000_000;
      $display("FAIL gain_scheduled_attitude_altitude_ctrl");
      $finish;
   end

   initial begin
      stim_row_type rows [$];
      command_type zero_cmd;
      sample_type s;
      logic [15:0] v;
      req_bus.valid = 1'b0;
      req_bus.pitch_angle = '0;
      req_bus.heading_angle = '0;
      req_bus.altitude = '0;
      req_bus.vertical_speed = '0;
      req_bus.step_time = '0;
      req_bus.sample_valid = 1'b0;
      m_armed = 0; m_alt_tgt = 256; m_pitch_tgt = 0; m_hdg_tgt = 0; m_hdg_given = 0;
      m_trim = 1638; m_pitch_int = 0; m_alt_int = 0; m_prev_pitch = 0; m_prev_hdg = 0;
      m_capt_hdg = 0; m_primed = 0; m_captured = 0; m_mode = MODE_LEVEL;
      zero_cmd = '{0, 0, 0, 0, MODE_LEVEL, 1'b0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disarmed after reset: neutral commands
      rows.push_back('{'{-15'sd16384, 15'd32767, -16'sd32768, 16'sd32767, 16'd0, 1'b1}, 1, zero_cmd});
      rows.push_back('{'{15'sd16383, 15'd0, 16'sd32767, -16'sd32768, 16'd65535, 1'b0}, 1, zero_cmd});
      rows.push_back('{'{15'sd11520, 15'd23040, 16'sd0, 16'sd0, 16'd1311, 1'b1}, 1, zero_cmd});
      foreach (rows[i]) send_sample(rows[i].s, rows[i].typed, rows[i].c);
      drain();
      write_reg(CSR_ARMED, 16'd1);
      rows.delete();
      // armed: an untrusted sample gives trim throttle, the rest are checked against the mirror
      rows.push_back('{'{15'sd0, 15'd100, 16'sd0, 16'sd0, 16'd1311, 1'b0}, 1,
                       '{0, 0, 1638, 0, MODE_LEVEL, 1'b1}});
      rows.push_back('{'{15'sd0, 15'd100, 16'sd256, 16'sd0, 16'd1311, 1'b1}, 0, zero_cmd});
      rows.push_back('{'{-15'sd11520, 15'd23040, 16'sd256, 16'sd77, 16'd0, 1'b1}, 0, zero_cmd});
      rows.push_back('{'{15'sd11520, 15'd0, 16'sd0, 16'sd30, 16'd32768, 1'b1}, 0, zero_cmd});
      rows.push_back('{'{15'sd16383, 15'd32767, -16'sd32768, 16'sd25, 16'd32769, 1'b1}, 0, zero_cmd});
      rows.push_back('{'{-15'sd16384, 15'd11520, 16'sd32767, -16'sd77, 16'd65535, 1'b1}, 0, zero_cmd});
      rows.push_back('{'{15'sd0, 15'd11521, 16'sd200, -16'sd30, 16'd1, 1'b1}, 0, zero_cmd});
      rows.push_back('{'{15'sd100, 15'd50, 16'sd300, -16'sd20, 16'd1311, 1'b1}, 0, zero_cmd});
      rows.push_back('{'{15'sd0, 15'd0, -16'sd32768, -16'sd32768, 16'd1311, 1'b1}, 0, zero_cmd});
      rows.push_back('{'{15'sd0, 15'd0, 16'sd32767, 16'sd32767, 16'd1311, 1'b1}, 0, zero_cmd});
      foreach (rows[i]) send_sample(rows[i].s, rows[i].typed, rows[i].c);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_ARMED, ph == 3 ? 16'd0 : 16'd1);
         case (ph)
            0: begin
               write_reg(CSR_ALT_TGT, 16'h8000);
               write_reg(CSR_PITCH_TGT, 16'h4000);
               write_reg(CSR_HDG_TGT, 16'd0);
               write_reg(CSR_HDG_GIVEN, 16'd1);
               write_reg(CSR_THR_TRIM, 16'd0);
            end
            1: begin
               write_reg(CSR_ALT_TGT, 16'h7FFF);
               write_reg(CSR_PITCH_TGT, 16'h3FFF);
               write_reg(CSR_HDG_TGT, 16'h7FFF);
               write_reg(CSR_HDG_GIVEN, 16'd0);
               write_reg(CSR_THR_TRIM, 16'h1FFF);
            end
            default: begin
               v = 16'($urandom);
               write_reg(CSR_ALT_TGT, $urandom_range(0, 1) ? v : 16'($urandom_range(0, 2048)));
               write_reg(CSR_PITCH_TGT, 16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000)));
               write_reg(CSR_HDG_TGT, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 23040)));
               write_reg(CSR_HDG_GIVEN, 16'($urandom_range(0, 1)));
               write_reg(CSR_THR_TRIM, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096)));
            end
         endcase
         max_gap = (ph == 5) ? 0 : 6;
         max_stall = (ph == 5) ? 0 : 6;
         if (ph == 2) hold_rsp = 1'b1;
         for (int n = 0; n < 250; n++) begin
            s = random_sample();
            send_sample(s, 1'b0, zero_cmd);
         end
         drain();
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      if (error_count == 0) begin
         $display("PASS gain_scheduled_attitude_altitude_ctrl");
      end else begin
         $display("FAIL gain_scheduled_attitude_altitude_ctrl");
      end
      $finish;
   end

endmodule
